@@ hw/rtl/bcc_pkg.sv @@
// Shared types and constants for the button click classifier.
// Holds phase and event codes, register indexes, reset values and the
// timeout helper. No dependencies.
package bcc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DurW   = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned EventW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE        = 3'd0;
  localparam logic [PhaseW-1:0] PH_DEB_PRESS   = 3'd1;
  localparam logic [PhaseW-1:0] PH_HOLD        = 3'd2;
  localparam logic [PhaseW-1:0] PH_DEB_RELEASE = 3'd3;
  localparam logic [PhaseW-1:0] PH_WAIT_DOUBLE = 3'd4;
  localparam logic [PhaseW-1:0] PH_DOUBLE_DONE = 3'd5;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE   = 2'd0;
  localparam logic [EventW-1:0] EV_SHORT  = 2'd1;
  localparam logic [EventW-1:0] EV_LONG   = 2'd2;
  localparam logic [EventW-1:0] EV_DOUBLE = 2'd3;

  // Request types
  localparam logic REQ_POLL  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK = 2'd2;

  localparam logic [DurW-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [DurW-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [DurW-1:0] DOUBLE_CLICK_RST = 16'd300;

  typedef struct packed {
    logic [DurW-1:0] debounce_ms;
    logic [DurW-1:0] long_press_ms;
    logic [DurW-1:0] double_click_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [EventW-1:0] latched_event;
    logic [TimeW-1:0]  phase_start;
    logic [TimeW-1:0]  press_start;
    logic [TimeW-1:0]  aux_start;
    logic              aux_timing;
    logic              fired;
  } bcc_state_t;

  typedef struct packed {
    logic             req_type;
    logic             pressed;
    logic [TimeW-1:0] now_ms;
  } bcc_req_t;

  // The timeout is reached once the wrapped time since start reaches dur.
  function automatic logic elapsed(logic [TimeW-1:0] now, logic [TimeW-1:0] start,
                                   logic [DurW-1:0] dur);
    logic [TimeW-1:0] diff;
    diff = now - start;
    return {{(TimeW-DurW){1'b0}}, dur} <= diff;
  endfunction

endpackage

@@ hw/rtl/bcc_ifs.sv @@
// Handshake channel interfaces for the button click classifier.
// Depends on bcc_pkg for field widths.
interface bcc_in_if;
  import bcc_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic             pressed;
  logic [TimeW-1:0] now_ms;
  modport source (output valid, req_type, pressed, now_ms, input ready);
  modport sink (input valid, req_type, pressed, now_ms, output ready);
endinterface

interface bcc_out_if;
  import bcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_code;
  logic [PhaseW-1:0] fsm_state;
  modport source (output valid, event_code, fsm_state, input ready);
  modport sink (input valid, event_code, fsm_state, output ready);
endinterface

interface bcc_cfg_if;
  import bcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DurW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bcc_step.sv @@
// Next-state logic of the click classifier for one request.
// Depends on bcc_pkg.
module bcc_step import bcc_pkg::*; (
  input  bcc_state_t cur,
  input  bcc_cfg_t   cfg,
  input  bcc_req_t   req,
  output bcc_state_t nxt
);

  logic deb_phase;
  logic deb_aux;
  logic long_hit;
  logic window_hit;

  assign deb_phase  = elapsed(req.now_ms, cur.phase_start, cfg.debounce_ms);
  assign deb_aux    = elapsed(req.now_ms, cur.aux_start, cfg.debounce_ms);
  assign long_hit   = elapsed(req.now_ms, cur.press_start, cfg.long_press_ms);
  assign window_hit = elapsed(req.now_ms, cur.phase_start, cfg.double_click_ms);

  always_comb begin
    nxt = cur;
    if (req.req_type == REQ_CLEAR) begin
      nxt.latched_event = EV_NONE;
    end else begin
      case (cur.phase)
        PH_IDLE: begin
          nxt.fired = 1'b0;
          nxt.aux_timing = 1'b0;
          if (req.pressed) begin
            nxt.phase = PH_DEB_PRESS;
            nxt.phase_start = req.now_ms;
          end
        end
        PH_DEB_PRESS: begin
          if (!req.pressed) begin
            nxt.phase = PH_IDLE;
          end else if (deb_phase) begin
            nxt.phase = PH_HOLD;
            nxt.press_start = req.now_ms;
          end
        end
        PH_HOLD: begin
          if (req.pressed) begin
            if (long_hit && !cur.fired) begin
              nxt.latched_event = EV_LONG;
              nxt.fired = 1'b1;
            end
          end else begin
            nxt.phase = PH_DEB_RELEASE;
            nxt.phase_start = req.now_ms;
          end
        end
        PH_DEB_RELEASE: begin
          if (req.pressed) begin
            nxt.phase = PH_HOLD;
          end else if (deb_phase) begin
            if (cur.fired) begin
              nxt.phase = PH_IDLE;
            end else begin
              nxt.phase = PH_WAIT_DOUBLE;
              nxt.phase_start = req.now_ms;
              nxt.aux_timing = 1'b0;
            end
          end
        end
        PH_WAIT_DOUBLE: begin
          if (req.pressed) begin
            if (!cur.aux_timing) begin
              nxt.aux_timing = 1'b1;
              nxt.aux_start = req.now_ms;
            end else if (deb_aux && !cur.fired) begin
              nxt.latched_event = EV_DOUBLE;
              nxt.fired = 1'b1;
              nxt.phase = PH_DOUBLE_DONE;
              nxt.aux_timing = 1'b0;
            end
          end else begin
            nxt.aux_timing = 1'b0;
            if (window_hit && !cur.fired) begin
              nxt.latched_event = EV_SHORT;
              nxt.phase = PH_IDLE;
            end
          end
        end
        PH_DOUBLE_DONE: begin
          if (req.pressed) begin
            nxt.aux_timing = 1'b0;
          end else if (!cur.aux_timing) begin
            nxt.aux_timing = 1'b1;
            nxt.aux_start = req.now_ms;
          end else if (deb_aux) begin
            nxt.phase = PH_IDLE;
            nxt.aux_timing = 1'b0;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
          nxt.aux_timing = 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/button_click_classifier_top.sv @@
// Top level of the button click classifier: request register, state update
// and result register. Depends on bcc_pkg, bcc_ifs and bcc_step.
//
//   channel | dir | payload                        | handshake
//   req     | in  | req_type, pressed, now_ms      | valid/ready
//   rsp     | out | event_code, fsm_state          | valid/ready
//   cfg     | in  | index, data (16 bit)           | valid/ready, ready always high
//
// One request per cycle is sustained while the result is not stalled; a result
// leaves through the request register, then the result register.
// The state update is a single pass of the phase machine and four 32-bit
// wrapped-difference compares between those two registers.
// Synchronous reset returns the phase machine, the event, both valid flags and
// the configuration registers to defaults; a stalled result holds each full stage.
module button_click_classifier_top import bcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bcc_in_if.sink     req,
  bcc_out_if.source  rsp,
  bcc_cfg_if.sink    cfg
);

  bcc_cfg_t   cfg_regs;
  bcc_state_t st;
  bcc_state_t st_next;
  bcc_req_t   req_q;
  logic       req_q_valid;
  logic       out_valid;
  logic [EventW-1:0] out_event;
  logic [PhaseW-1:0] out_phase;
  logic       out_load;
  logic       do_step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ms     <= DEBOUNCE_RST;
      cfg_regs.long_press_ms   <= LONG_PRESS_RST;
      cfg_regs.double_click_ms <= DOUBLE_CLICK_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE:     cfg_regs.debounce_ms <= cfg.data;
        REG_LONG_PRESS:   cfg_regs.long_press_ms <= cfg.data;
        REG_DOUBLE_CLICK: cfg_regs.double_click_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  // The result register takes a new value when it is empty or being drained.
  assign out_load  = !out_valid || rsp.ready;
  assign do_step   = req_q_valid && out_load;
  assign req.ready = !req_q_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req.ready) begin
      req_q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      req_q.req_type <= req.req_type;
      req_q.pressed  <= req.pressed;
      req_q.now_ms   <= req.now_ms;
    end
  end

  bcc_step u_step (
    .cur (st),
    .cfg (cfg_regs),
    .req (req_q),
    .nxt (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (do_step) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= req_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_event <= st_next.latched_event;
      out_phase <= st_next.phase;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.event_code = out_event;
  assign rsp.fsm_state  = out_phase;

  // A processed clear request always leaves the event at none.
  a_clear_event: assert property (@(posedge clk) disable iff (rst)
    do_step && req_q.req_type == REQ_CLEAR |=> st.latched_event == EV_NONE)
    else $error("clear request did not reset the latched event");

  // State only moves when a request is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !do_step |=> $stable(st))
    else $error("state changed without a processed request");

  // A result appears only for a request held in the request register.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(req_q_valid))
    else $error("result raised without a pending request");

  // The final release after a double click is only reached with the event fired.
  a_double_fired: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_DOUBLE_DONE |-> st.fired)
    else $error("double-done phase without fired flag");

endmodule
